[hdl/sha256s_pkg.sv]
// Shared types, constants and functions for the SHA-256 stream hasher.
// Used by the round core and the top level; depends on nothing else.
package sha256s_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    typedef struct packed {
        logic       w_push;
        logic       v_shift;
        logic       round_en;
        logic [5:0] round_idx;
    } dp_ctrl_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;
    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] h;
        case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

[hdl/sha256_stream_hasher.sv]
// SHA-256 stream hasher. An absorb transfer stores one byte; item_ready stays high unless the
// transfer fills a block, which starts a compression (streaming the block and hash words out
// of the RAMs, 64 rounds at one round per cycle in the single round unit, then the
// read-modify-write of the hash RAM), during which item_ready is low. A finish transfer writes
// the padding one word per cycle, runs one or two compressions, then delivers the eight digest
// words: a word is read from the hash RAM only once the output register is free, and the read
// data is captured into that register in S_EMIT_CAP. The hash words reset to the initial
// values through per-word valid bits, so no clearing pass is needed after reset.
module sha256_stream_hasher
    import sha256s_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PAD      = 3'd1;
    localparam logic [2:0] S_LOAD     = 3'd2;
    localparam logic [2:0] S_ROUND    = 3'd3;
    localparam logic [2:0] S_UPDATE   = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;
    localparam logic [2:0] S_EMIT_CAP = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg, total_next;
    logic        fin_reg, fin_next;
    logic        extra_reg, extra_next;
    logic [4:0]  pad_idx_reg, pad_idx_next;
    logic [7:0]  hv_reg, hv_next;
    logic        result_valid_reg, result_valid_next;
    logic [23:0] acc_reg, acc_next;
    result_t     result_reg, result_next;
    logic [2:0]  rd_addr_reg;
    logic        rd_valid_reg;

    logic        blk_we;
    logic [3:0]  blk_waddr;
    logic [31:0] blk_wdata;
    logic        blk_re;
    logic [3:0]  blk_raddr;
    logic [31:0] blk_q;
    logic        hash_we;
    logic [2:0]  hash_waddr;
    logic [31:0] hash_wdata;
    logic        hash_re;
    logic [2:0]  hash_raddr;
    logic [31:0] hash_q;
    logic [31:0] hash_rd;
    logic [31:0] v_head;
    logic [5:0]  cnt_m1;
    logic [63:0] bit_len;
    logic [31:0] pad_word;
    dp_ctrl_t    ctrl;

    sha256s_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_block_ram (
        .clk   (clk),
        .we    (blk_we),
        .waddr (blk_waddr),
        .wdata (blk_wdata),
        .re    (blk_re),
        .raddr (blk_raddr),
        .rdata (blk_q)
    );

    sha256s_ram #(
        .WIDTH(32),
        .DEPTH(8)
    ) u_hash_ram (
        .clk   (clk),
        .we    (hash_we),
        .waddr (hash_waddr),
        .wdata (hash_wdata),
        .re    (hash_re),
        .raddr (hash_raddr),
        .rdata (hash_q)
    );

    sha256s_round_core u_round_core (
        .clk    (clk),
        .ctrl   (ctrl),
        .w_data (blk_q),
        .v_data (hash_rd),
        .v_head (v_head)
    );

    // A hash word that was never written since the last reset or digest reads as its IV.
    assign hash_rd = rd_valid_reg ? hash_q : init_hash(rd_addr_reg);
    assign cnt_m1  = cnt_reg - 6'd1;
    assign bit_len = {total_reg, 3'b000};

    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_MARK, 24'd0};
            2'd1:    pad_word = {acc_reg[7:0], PAD_MARK, 16'd0};
            2'd2:    pad_word = {acc_reg[15:0], PAD_MARK, 8'd0};
            default: pad_word = {acc_reg[23:0], PAD_MARK};
        endcase
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        fill_next         = fill_reg;
        total_next        = total_reg;
        fin_next          = fin_reg;
        extra_next        = extra_reg;
        pad_idx_next      = pad_idx_reg;
        hv_next           = hv_reg;
        acc_next          = acc_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        blk_we            = 1'b0;
        blk_waddr         = fill_reg[5:2];
        blk_wdata         = pad_word;
        blk_re            = 1'b0;
        blk_raddr         = cnt_reg[3:0];
        hash_we           = 1'b0;
        hash_waddr        = cnt_m1[2:0];
        hash_wdata        = hash_rd + v_head;
        hash_re           = 1'b0;
        hash_raddr        = cnt_reg[2:0];
        ctrl              = '0;
        ctrl.round_idx    = cnt_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.opcode == OP_ABSORB)
                    begin
                        acc_next   = {acc_reg[15:0], item.data_byte};
                        fill_next  = fill_reg + 6'd1;
                        total_next = total_reg + 61'd1;
                        if (fill_reg[1:0] == 2'd3)
                        begin
                            blk_we    = 1'b1;
                            blk_wdata = {acc_reg, item.data_byte};
                        end
                        if (fill_reg == 6'd63)
                        begin
                            state_next = S_LOAD;
                            cnt_next   = 6'd0;
                        end
                    end
                    else
                    begin
                        blk_we       = 1'b1;
                        blk_wdata    = pad_word;
                        pad_idx_next = {1'b0, fill_reg[5:2]} + 5'd1;
                        extra_next   = (fill_reg[5:2] >= 4'd14);
                        fin_next     = 1'b1;
                        fill_next    = 6'd0;
                        state_next   = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (pad_idx_reg[4])
                begin
                    state_next = S_LOAD;
                    cnt_next   = 6'd0;
                end
                else
                begin
                    blk_we    = 1'b1;
                    blk_waddr = pad_idx_reg[3:0];
                    if (!extra_reg && pad_idx_reg[3:0] == 4'd14)
                    begin
                        blk_wdata = bit_len[63:32];
                    end
                    else if (!extra_reg && pad_idx_reg[3:0] == 4'd15)
                    begin
                        blk_wdata = bit_len[31:0];
                    end
                    else
                    begin
                        blk_wdata = 32'd0;
                    end
                    pad_idx_next = pad_idx_reg + 5'd1;
                end
            end
            S_LOAD:
            begin
                if (cnt_reg < 6'd16)
                begin
                    blk_re = 1'b1;
                end
                if (cnt_reg < 6'd8)
                begin
                    hash_re = 1'b1;
                end
                if (cnt_reg != 6'd0)
                begin
                    ctrl.w_push = 1'b1;
                end
                if (cnt_reg != 6'd0 && cnt_reg <= 6'd8)
                begin
                    ctrl.v_shift = 1'b1;
                end
                if (cnt_reg == 6'd16)
                begin
                    state_next = S_ROUND;
                    cnt_next   = 6'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_ROUND:
            begin
                ctrl.round_en = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    state_next = S_UPDATE;
                    cnt_next   = 6'd0;
                end
            end
            S_UPDATE:
            begin
                if (cnt_reg < 6'd8)
                begin
                    hash_re = 1'b1;
                end
                if (cnt_reg != 6'd0)
                begin
                    hash_we               = 1'b1;
                    hv_next[cnt_m1[2:0]]  = 1'b1;
                    ctrl.v_shift          = 1'b1;
                end
                if (cnt_reg == 6'd8)
                begin
                    cnt_next = 6'd0;
                    if (!fin_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (extra_reg)
                    begin
                        extra_next   = 1'b0;
                        pad_idx_next = 5'd0;
                        state_next   = S_PAD;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    hash_re    = 1'b1;
                    state_next = S_EMIT_CAP;
                end
            end
            S_EMIT_CAP:
            begin
                result_next.digest_word = hash_rd;
                result_next.word_index  = cnt_reg[2:0];
                result_next.last_word   = (cnt_reg[2:0] == 3'd7);
                result_valid_next       = 1'b1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    hv_next    = 8'd0;
                    total_next = 61'd0;
                    fin_next   = 1'b0;
                    cnt_next   = 6'd0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= 6'd0;
            fill_reg         <= 6'd0;
            total_reg        <= 61'd0;
            fin_reg          <= 1'b0;
            extra_reg        <= 1'b0;
            pad_idx_reg      <= 5'd0;
            hv_reg           <= 8'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            fill_reg         <= fill_next;
            total_reg        <= total_next;
            fin_reg          <= fin_next;
            extra_reg        <= extra_next;
            pad_idx_reg      <= pad_idx_next;
            hv_reg           <= hv_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        result_reg   <= result_next;
        rd_addr_reg  <= hash_raddr;
        rd_valid_reg <= hv_reg[hash_raddr];
    end

    a_hash_rmw_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (hash_we && hash_re) |-> (hash_waddr != hash_raddr))
        else $error("hash RAM read and write hit the same word");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_CAP) |-> !result_valid_reg)
        else $error("digest word would overwrite a pending transfer");

    a_finish_pads: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.opcode == OP_FINISH) |=> (state_reg == S_PAD))
        else $error("finish transfer did not start padding");

    a_extra_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> fin_reg)
        else $error("extra padding block outside a finish");

    a_iv_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_CAP && cnt_reg[2:0] == 3'd7) |=> (hv_reg == 8'd0))
        else $error("hash words not returned to initial values");

endmodule

[hdl/sha256s_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the block buffer and the chaining hash words; no dependencies.
module sha256s_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sha256s_round_core.sv]
// Working variables, sixteen-word schedule window and the SHA-256 round logic.
// Depends on sha256s_pkg for the control struct, round constants and rotations.
module sha256s_round_core
    import sha256s_pkg::*;
(
    input  logic        clk,
    input  dp_ctrl_t    ctrl,
    input  logic [31:0] w_data,
    input  logic [31:0] v_data,
    output logic [31:0] v_head
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic [31:0] sig1_e;
    logic [31:0] sig0_a;
    logic [31:0] ch_efg;
    logic [31:0] maj_abc;
    logic [31:0] sch0;
    logic [31:0] sch1;

    always_comb
    begin
        sig1_e  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        sig0_a  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch_efg  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj_abc = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1      = v_reg[7] + sig1_e + ch_efg + round_k(ctrl.round_idx) + w_reg[0];
        t2      = sig0_a + maj_abc;
        sch0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sch1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new   = sch1 + w_reg[9] + sch0 + w_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.w_push || ctrl.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= ctrl.round_en ? w_new : w_data;
        end
        if (ctrl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (ctrl.v_shift)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i + 1];
            end
            v_reg[7] <= v_data;
        end
    end

    assign v_head = v_reg[0];

endmodule

[test/tb_sha256_stream_hasher.sv]
// Testbench for sha256_stream_hasher: byte streams with random bursts, gaps and output stalls.
// A scoreboard class predicts the digest words of each message and checks them in order.
// Depends on sha256s_pkg and the RTL of the hasher only.
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;
    import sha256s_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 10;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int DRAIN_CYCLES = 300;
    localparam int MIN_ITEMS = 160;
    localparam int MIN_MESSAGES = 8;

    class digest_tracker;
        localparam logic [31:0] ROUND_CONST [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        localparam logic [31:0] START_HASH [8] = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
        };

        logic [31:0] chain [8];
        logic [7:0]  block_bytes [64];
        int unsigned fill;
        logic [60:0] byte_count;
        result_t     pending_digest_words [$];
        int          errors;

        function new();
            errors = 0;
            start_message();
        endfunction

        function void start_message();
            for (int i = 0; i < 8; i++)
            begin
                chain[i] = START_HASH[i];
            end
            fill = 0;
            byte_count = '0;
        endfunction

        function logic [31:0] ror(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1;
            logic [31:0] t2;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                        block_bytes[4*i+3]};
            end
            for (int i = 16; i < 64; i++)
            begin
                w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            end
            for (int i = 0; i < 8; i++)
            begin
                v[i] = chain[i];
            end
            for (int r = 0; r < 64; r++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
            begin
                chain[i] = chain[i] + v[i];
            end
            fill = 0;
        endfunction

        function void take_item(input item_t it);
            logic [63:0] bit_length;
            result_t     word;
            if (it.opcode == OP_ABSORB)
            begin
                block_bytes[fill] = it.data_byte;
                fill++;
                byte_count = byte_count + 61'd1;
                if (fill == 64)
                    compress();
                return;
            end
            block_bytes[fill] = PAD_MARK;
            fill++;
            if (fill > 56)
            begin
                for (int i = fill; i < 64; i++)
                    block_bytes[i] = 8'h00;
                compress();
            end
            for (int i = fill; i < 56; i++)
                block_bytes[i] = 8'h00;
            bit_length = {byte_count, 3'b000};
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = bit_length[63 - 8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                word.digest_word = chain[i];
                word.word_index = i[2:0];
                word.last_word = (i == 7);
                pending_digest_words.push_back(word);
            end
            start_message();
        endfunction

        function void check_word(input result_t got);
            result_t want;
            if (pending_digest_words.size() == 0)
            begin
                $error("unexpected digest word %h at index %0d", got.digest_word,
                       got.word_index);
                errors++;
                return;
            end
            want = pending_digest_words.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $error("digest_word: expected %h, actual %h", want.digest_word,
                       got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $error("word_index: expected %0d, actual %0d", want.word_index,
                       got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $error("last_word: expected %b, actual %b", want.last_word, got.last_word);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_digest_words.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    digest_tracker tracker = new();
    int  burst_left;
    int  items_sent;
    int  messages_sent;
    bit  hold_off_request;

    sha256_stream_hasher uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic op, input logic [7:0] value);
        item_t next;
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        next.opcode = op;
        next.data_byte = value;
        item_valid <= 1'b1;
        item <= next;
        do
            @(posedge clk);
        while (!item_ready);
        tracker.take_item(next);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_message(input int length);
        for (int i = 0; i < length; i++)
            send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
        send_item(OP_FINISH, 8'($urandom_range(0, 255)));
        messages_sent++;
    endtask

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 8);
        if (sel < 7)
        begin
            case ($urandom_range(0, 7))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                5: return 65;
                6: return 119;
                default: return 128;
            endcase
        end
        return $urandom_range(0, 80);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        burst_left = 0;
        items_sent = 0;
        messages_sent = 0;
        hold_off_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty message, with a data byte on the finish that must be ignored.
        send_item(OP_FINISH, 8'hff);
        messages_sent++;
        send_item(OP_ABSORB, 8'h61);
        send_item(OP_ABSORB, 8'h62);
        send_item(OP_ABSORB, 8'h63);
        send_item(OP_FINISH, 8'h00);
        messages_sent++;
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_ABSORB, PAD_MARK);
        send_item(OP_FINISH, 8'h5a);
        messages_sent++;
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_FINISH, 8'hff);
        messages_sent++;

        hold_off_request = 1'b1;
        while (items_sent < MIN_ITEMS || messages_sent < MIN_MESSAGES)
            send_message(pick_length());
        item_valid <= 1'b0;

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int unsigned cycle;
        int unsigned mode;
        cycle = 0;
        mode = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (cycle % 48 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: result_ready <= 1'b1;
                1: result_ready <= $urandom_range(0, 1);
                2: result_ready <= ($urandom_range(0, 3) != 0);
                default: result_ready <= (cycle % 11 < 3);
            endcase
            cycle++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_word(result);
    end

    initial
    begin
        #(2 * HALF_PERIOD * 250000);
        $display("Some tests failed");
        $finish;
    end

endmodule
